// ----- sv/c2d_pkg.sv -----
// ----------------------------------------------------------------------------
// c2d_pkg: shared types and constants of the 5x5 RGB convolution
// Sizes, tap request and emit descriptors, the coefficient reset value and
// the final round-and-clamp function.
// ----------------------------------------------------------------------------
package c2d_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MASK_SIZE  = 5;
  localparam int RADIUS     = MASK_SIZE / 2;
  localparam int TAPS       = MASK_SIZE * MASK_SIZE;
  localparam int PIX_W      = 8;
  localparam int CH         = 3;
  localparam int RGB_W      = PIX_W * CH;
  localparam int COEF_W     = 12;
  localparam int COEF_FRAC  = COEF_W - 2;
  localparam int MASK_W     = COEF_W * MASK_SIZE;
  localparam int DIM_W      = 11;
  localparam int LIN_W      = 20;
  localparam int BASE_W     = 21;
  localparam int AGE_W      = 22;
  localparam int HIST_DEPTH = 4 * MAX_WIDTH + 8;
  // A few spare entries so that a tap cannot be overwritten while in flight.
  localparam int MEM_DEPTH  = HIST_DEPTH + 8;
  localparam int PTR_W      = $clog2(MEM_DEPTH);
  localparam int PROD_W     = PIX_W + 1 + COEF_W;
  localparam int ROWSUM_W   = PROD_W + 3;
  localparam int SUM_W      = ROWSUM_W + 3;
  localparam int OUT_MAX    = 255;

  localparam logic [MASK_W-1:0] MASK_ROW2_RST =
    MASK_W'(1 << COEF_FRAC) << (COEF_W * RADIUS);

  typedef enum logic [2:0] {
    CFG_MASK0  = 3'd0,
    CFG_MASK1  = 3'd1,
    CFG_MASK2  = 3'd2,
    CFG_MASK3  = 3'd3,
    CFG_MASK4  = 3'd4,
    CFG_WIDTH  = 3'd5,
    CFG_HEIGHT = 3'd6
  } cfg_idx_e;

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  typedef struct packed {
    logic             ok;
    logic [PTR_W-1:0] idx;
  } tap_req_t;

  typedef struct packed {
    logic             vld;
    logic             last;
    logic [DIM_W-1:0] orow;
    logic [DIM_W-1:0] ocol;
    logic [LIN_W-1:0] newest;
    logic             newest_ok;
    logic [PTR_W-1:0] nptr;
  } emit_t;

  function automatic logic [PIX_W-1:0] round_clamp(input sum_t s);
    logic signed [SUM_W:0] t;
    logic signed [SUM_W:0] v;
    begin
      t = (SUM_W+1)'(s) + (SUM_W+1)'(1 << (COEF_FRAC - 1));
      v = t >>> COEF_FRAC;
      if (t <= 0) begin
        round_clamp = '0;
      end else if (v > OUT_MAX) begin
        round_clamp = PIX_W'(OUT_MAX);
      end else begin
        round_clamp = v[PIX_W-1:0];
      end
    end
  endfunction

endpackage

// ----- sv/c2d_addr.sv -----
// ----------------------------------------------------------------------------
// c2d_addr: tap address generator
// Turns one output position into 25 history addresses with a valid flag each,
// over three register stages.
// ----------------------------------------------------------------------------
module c2d_addr (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            adv_i,
  input  c2d_pkg::emit_t                  emit_i,
  input  logic [c2d_pkg::DIM_W-1:0]       width_i,
  input  logic [c2d_pkg::DIM_W-1:0]       height_i,
  output c2d_pkg::tap_req_t               req_o [c2d_pkg::TAPS],
  output logic                            vld_o,
  output logic                            last_o
);
  import c2d_pkg::*;

  logic                  s1_vld_q, s2_vld_q, s3_vld_q;
  logic                  s1_last_q, s2_last_q, s3_last_q;
  logic [BASE_W-1:0]     s1_base_q [MASK_SIZE];
  logic                  s1_rok_q  [MASK_SIZE];
  logic [DIM_W-1:0]      s1_cc_q   [MASK_SIZE];
  logic                  s1_cok_q  [MASK_SIZE];
  logic [LIN_W-1:0]      s1_newest_q;
  logic                  s1_nok_q;
  logic [PTR_W-1:0]      s1_nptr_q, s2_nptr_q;
  logic [PTR_W-1:0]      s2_age_q [TAPS];
  logic                  s2_ok_q  [TAPS];

  logic [BASE_W-1:0]     s1_base_d [MASK_SIZE];
  logic                  s1_rok_d  [MASK_SIZE];
  logic [DIM_W-1:0]      s1_cc_d   [MASK_SIZE];
  logic                  s1_cok_d  [MASK_SIZE];
  logic [PTR_W-1:0]      s2_age_d  [TAPS];
  logic                  s2_ok_d   [TAPS];
  tap_req_t              s3_req_d  [TAPS];

  // Stage 1: row bases and column positions.
  always_comb begin
    logic [DIM_W+1:0] rr;
    logic [DIM_W+1:0] cc;
    logic [2*DIM_W-1:0] prod;
    for (int k = 0; k < MASK_SIZE; k++) begin
      rr = {2'b00, emit_i.orow} + (DIM_W+2)'(k) - (DIM_W+2)'(RADIUS);
      cc = {2'b00, emit_i.ocol} + (DIM_W+2)'(k) - (DIM_W+2)'(RADIUS);
      prod = rr[DIM_W-1:0] * width_i;
      s1_base_d[k] = prod[BASE_W-1:0];
      s1_rok_d[k]  = !rr[DIM_W+1] && (rr[DIM_W:0] < {1'b0, height_i});
      s1_cc_d[k]   = cc[DIM_W-1:0];
      s1_cok_d[k]  = !cc[DIM_W+1] && (cc[DIM_W:0] < {1'b0, width_i});
    end
  end

  // Stage 2: linear index and age of every tap.
  always_comb begin
    logic [BASE_W-1:0] lin;
    logic [AGE_W-1:0]  age;
    for (int t = 0; t < TAPS; t++) begin
      lin = s1_base_q[t / MASK_SIZE] + BASE_W'(s1_cc_q[t % MASK_SIZE]);
      age = AGE_W'(s1_newest_q) - AGE_W'(lin);
      s2_age_d[t] = age[PTR_W-1:0];
      s2_ok_d[t]  = s1_rok_q[t / MASK_SIZE] && s1_cok_q[t % MASK_SIZE] && s1_nok_q &&
                    !age[AGE_W-1] && (age < AGE_W'(HIST_DEPTH));
    end
  end

  // Stage 3: age to physical address in the circular history.
  always_comb begin
    logic [PTR_W:0] diff;
    for (int t = 0; t < TAPS; t++) begin
      diff = {1'b0, s2_nptr_q} - {1'b0, s2_age_q[t]};
      if (diff[PTR_W]) begin
        diff = diff + (PTR_W+1)'(MEM_DEPTH);
      end
      s3_req_d[t].idx = diff[PTR_W-1:0];
      s3_req_d[t].ok  = s2_ok_q[t];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else if (adv_i) begin
      s1_vld_q <= emit_i.vld;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_last_q   <= emit_i.last;
      s1_newest_q <= emit_i.newest;
      s1_nok_q    <= emit_i.newest_ok;
      s1_nptr_q   <= emit_i.nptr;
      s1_base_q   <= s1_base_d;
      s1_rok_q    <= s1_rok_d;
      s1_cc_q     <= s1_cc_d;
      s1_cok_q    <= s1_cok_d;
      s2_last_q   <= s1_last_q;
      s2_nptr_q   <= s1_nptr_q;
      s2_age_q    <= s2_age_d;
      s2_ok_q     <= s2_ok_d;
      s3_last_q   <= s2_last_q;
      req_o       <= s3_req_d;
    end
  end

  assign vld_o  = s3_vld_q;
  assign last_o = s3_last_q;

endmodule

// ----- sv/c2d_lane.sv -----
// ----------------------------------------------------------------------------
// c2d_lane: one tap lane
// Holds its own copy of the pixel history, reads the tap it is given and
// weights all three channels with the lane's coefficient.
// ----------------------------------------------------------------------------
module c2d_lane (
  input  logic                           clk_i,
  input  logic                           adv_i,
  input  logic                           wr_en_i,
  input  logic [c2d_pkg::PTR_W-1:0]      wr_ptr_i,
  input  logic [c2d_pkg::RGB_W-1:0]      wr_pix_i,
  input  c2d_pkg::tap_req_t              req_i,
  input  logic [c2d_pkg::COEF_W-1:0]     coef_i,
  output c2d_pkg::prod_t                 prod_o [c2d_pkg::CH]
);
  import c2d_pkg::*;

  logic [RGB_W-1:0] mem [MEM_DEPTH];
  logic [RGB_W-1:0] rd_q;
  logic             ok_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_ptr_i] <= wr_pix_i;
    end
    if (adv_i) begin
      rd_q <= mem[req_i.idx];
      ok_q <= req_i.ok;
    end
  end

  // Taps outside the frame or history contribute nothing.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int c = 0; c < CH; c++) begin
        prod_o[c] <= ok_q ? PROD_W'($signed({1'b0, rd_q[PIX_W*c +: PIX_W]}) *
                                    $signed(coef_i)) : '0;
      end
    end
  end

endmodule

// ----- sv/c2d_merge.sv -----
// ----------------------------------------------------------------------------
// c2d_merge: lane merge
// Registered adder tree over the 25 lanes: row sums, then the window sum.
// ----------------------------------------------------------------------------
module c2d_merge (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic              vld_i,
  input  logic              last_i,
  input  c2d_pkg::prod_t    prod_i [c2d_pkg::TAPS][c2d_pkg::CH],
  output c2d_pkg::sum_t     sum_o  [c2d_pkg::CH],
  output logic              vld_o,
  output logic              last_o
);
  import c2d_pkg::*;

  logic signed [ROWSUM_W-1:0] row_q [MASK_SIZE][CH];
  logic signed [ROWSUM_W-1:0] row_d [MASK_SIZE][CH];
  sum_t                       sum_d [CH];
  logic                       vld_q, last_q;

  always_comb begin
    for (int r = 0; r < MASK_SIZE; r++) begin
      for (int c = 0; c < CH; c++) begin
        row_d[r][c] = '0;
        for (int k = 0; k < MASK_SIZE; k++) begin
          row_d[r][c] = row_d[r][c] + ROWSUM_W'(prod_i[r*MASK_SIZE + k][c]);
        end
      end
    end
    for (int c = 0; c < CH; c++) begin
      sum_d[c] = '0;
      for (int r = 0; r < MASK_SIZE; r++) begin
        sum_d[c] = sum_d[c] + SUM_W'(row_q[r][c]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      vld_o <= 1'b0;
    end else if (adv_i) begin
      vld_q <= vld_i;
      vld_o <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      row_q  <= row_d;
      last_q <= last_i;
      sum_o  <= sum_d;
      last_o <= last_q;
    end
  end

endmodule

// ----- sv/conv2d_5x5_rgb_clamp.sv -----
// ----------------------------------------------------------------------------
// conv2d_5x5_rgb_clamp: streaming 5x5 RGB convolution with zero padding
// Raster-order pixel stream in, convolved and saturated pixel stream out.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid_i / in_stall_o) carries one pixel per transfer
// when func_i is 0, or a flush tick when func_i is 1. The output channel
// (out_valid_o / out_stall_i) carries one convolved pixel per transfer, with
// frame_last_o marking the final pixel of the frame. Output pixel n of a frame
// is produced by input pixel n + 2*width + 2; once the whole frame is in,
// each flush tick drains one more pending output. A pixel arriving after a
// complete frame starts a new frame and drops anything still pending.
// Throughput is one transfer per clock in both directions while the receiver
// does not stall. An input transfer passes eight register stages before its
// output is presented: the address generator (3), the per-lane history read
// (1), the multipliers (1), the adder tree (2) and the round/clamp output
// register (1), and the first of them loads at the accepting edge itself.
// Each of the 25 lanes holds its own copy of the 4104-entry pixel history,
// plus eight spare entries, so that every tap has a dedicated read port.
// When the receiver stalls and the output register is full, the whole
// pipeline freezes and in_stall_o rises in the same cycle.
// Reset clears all counters and valid flags and loads the identity kernel
// with a 1024x1024 frame; the history memories are not cleared, because only
// pixels of the current frame are ever read.
// Configuration writes are taken at any edge with cfg_we_i high and must only
// happen while the pipeline is empty.
// ----------------------------------------------------------------------------
module conv2d_5x5_rgb_clamp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [2:0]                   cfg_idx_i,
  input  logic [c2d_pkg::MASK_W-1:0]   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         func_i,
  input  logic [c2d_pkg::PIX_W-1:0]    red_in_i,
  input  logic [c2d_pkg::PIX_W-1:0]    green_in_i,
  input  logic [c2d_pkg::PIX_W-1:0]    blue_in_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [c2d_pkg::PIX_W-1:0]    red_out_o,
  output logic [c2d_pkg::PIX_W-1:0]    green_out_o,
  output logic [c2d_pkg::PIX_W-1:0]    blue_out_o,
  output logic                         frame_last_o
);
  import c2d_pkg::*;

  // Configuration registers.
  logic [MASK_W-1:0] mask_q [MASK_SIZE];
  logic [DIM_W-1:0]  width_cfg_q, height_cfg_q;

  // Raster counters and history bookkeeping.
  logic [DIM_W-1:0]   in_row_q, out_row_q;
  logic [DIM_W-2:0]   in_col_q, out_col_q;
  logic [PTR_W-1:0]   wr_ptr_q, nptr_q;
  logic [LIN_W-1:0]   newest_q;
  logic               nok_q;

  // Output register.
  logic               out_valid_q;
  logic [PIX_W-1:0]   out_pix_q [CH];
  logic               out_last_q;

  logic               adv, in_fire, is_pix, restart, emit;
  logic [DIM_W-1:0]   w_eff, h_eff;
  logic [DIM_W-1:0]   row0, orow0, col0, ocol0, col1, ocol1;
  logic [2*DIM_W-1:0] lin, lag;
  emit_t              emit_s;

  tap_req_t           req   [TAPS];
  prod_t              prod  [TAPS][CH];
  sum_t               sum   [CH];
  logic [COEF_W-1:0]  coef  [TAPS];
  logic               a_vld, a_last, s4_vld_q, s5_vld_q, s4_last_q, s5_last_q;
  logic               m_vld, m_last;

  // The whole pipeline moves whenever the output register can take a result.
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;
  assign in_fire    = in_valid_i && adv;
  assign is_pix     = !func_i;

  // Out-of-range geometry is folded into the legal range.
  always_comb begin
    if (width_cfg_q == '0) begin
      w_eff = DIM_W'(1);
    end else if (width_cfg_q > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = width_cfg_q;
    end
    if (height_cfg_q == '0) begin
      h_eff = DIM_W'(1);
    end else if (height_cfg_q > DIM_W'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_cfg_q;
    end
  end

  // A pixel that follows a complete frame opens a new frame.
  assign restart = is_pix && (in_row_q >= h_eff);
  assign row0    = restart ? '0 : in_row_q;
  assign col0    = restart ? '0 : {1'b0, in_col_q};
  assign orow0   = restart ? '0 : out_row_q;
  assign ocol0   = restart ? '0 : {1'b0, out_col_q};
  assign col1    = col0 + DIM_W'(1);
  assign ocol1   = ocol0 + DIM_W'(1);

  assign lin = row0 * w_eff + (2*DIM_W)'(col0);
  assign lag = (2*DIM_W)'(RADIUS) * (2*DIM_W)'(w_eff) + (2*DIM_W)'(RADIUS);

  // A pixel emits once it completes the lower right corner of a window;
  // a flush emits only after the whole frame has arrived.
  always_comb begin
    if (is_pix) begin
      emit = in_fire && (lin >= lag) && (orow0 < h_eff);
    end else begin
      emit = in_fire && (in_row_q >= h_eff) && (out_row_q < h_eff);
    end
  end

  always_comb begin
    emit_s.vld       = emit;
    emit_s.last      = (orow0 == h_eff - DIM_W'(1)) && (ocol0 == w_eff - DIM_W'(1));
    emit_s.orow      = orow0;
    emit_s.ocol      = ocol0;
    emit_s.newest    = is_pix ? lin[LIN_W-1:0] : newest_q;
    emit_s.newest_ok = is_pix ? 1'b1 : nok_q;
    emit_s.nptr      = is_pix ? wr_ptr_q : nptr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < MASK_SIZE; r++) begin
        mask_q[r] <= (r == RADIUS) ? MASK_ROW2_RST : '0;
      end
      width_cfg_q  <= DIM_W'(MAX_WIDTH);
      height_cfg_q <= DIM_W'(MAX_HEIGHT);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MASK0:  mask_q[0]    <= cfg_data_i;
        CFG_MASK1:  mask_q[1]    <= cfg_data_i;
        CFG_MASK2:  mask_q[2]    <= cfg_data_i;
        CFG_MASK3:  mask_q[3]    <= cfg_data_i;
        CFG_MASK4:  mask_q[4]    <= cfg_data_i;
        CFG_WIDTH:  width_cfg_q  <= cfg_data_i[DIM_W-1:0];
        CFG_HEIGHT: height_cfg_q <= cfg_data_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q  <= '0;
      in_col_q  <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
      wr_ptr_q  <= '0;
      nptr_q    <= '0;
      newest_q  <= '0;
      nok_q     <= 1'b0;
    end else if (in_fire) begin
      if (is_pix) begin
        nptr_q   <= wr_ptr_q;
        wr_ptr_q <= (wr_ptr_q == PTR_W'(MEM_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
        newest_q <= lin[LIN_W-1:0];
        nok_q    <= 1'b1;
        if (col1 >= w_eff) begin
          in_col_q <= '0;
          in_row_q <= row0 + DIM_W'(1);
        end else begin
          in_col_q <= col1[DIM_W-2:0];
          in_row_q <= row0;
        end
      end
      if (emit) begin
        if (ocol1 >= w_eff) begin
          out_col_q <= '0;
          out_row_q <= orow0 + DIM_W'(1);
        end else begin
          out_col_q <= ocol1[DIM_W-2:0];
          out_row_q <= orow0;
        end
      end else begin
        out_col_q <= ocol0[DIM_W-2:0];
        out_row_q <= orow0;
      end
    end
  end

  c2d_addr u_addr (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .emit_i   (emit_s),
    .width_i  (w_eff),
    .height_i (h_eff),
    .req_o    (req),
    .vld_o    (a_vld),
    .last_o   (a_last)
  );

  for (genvar t = 0; t < TAPS; t++) begin : g_lane
    assign coef[t] = mask_q[t / MASK_SIZE][COEF_W*(t % MASK_SIZE) +: COEF_W];

    c2d_lane u_lane (
      .clk_i    (clk_i),
      .adv_i    (adv),
      .wr_en_i  (in_fire && is_pix),
      .wr_ptr_i (wr_ptr_q),
      .wr_pix_i ({blue_in_i, green_in_i, red_in_i}),
      .req_i    (req[t]),
      .coef_i   (coef[t]),
      .prod_o   (prod[t])
    );
  end

  // Valid and frame-end flags ride along with the lane read and multiply.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
    end else if (adv) begin
      s4_vld_q <= a_vld;
      s5_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_last_q <= a_last;
      s5_last_q <= s4_last_q;
    end
  end

  c2d_merge u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (s5_vld_q),
    .last_i (s5_last_q),
    .prod_i (prod),
    .sum_o  (sum),
    .vld_o  (m_vld),
    .last_o (m_last)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= m_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < CH; c++) begin
        out_pix_q[c] <= round_clamp(sum[c]);
      end
      out_last_q <= m_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign red_out_o    = out_pix_q[0];
  assign green_out_o  = out_pix_q[1];
  assign blue_out_o   = out_pix_q[2];
  assign frame_last_o = out_last_q;

endmodule

// ----- sv/c2d_checker.sv -----
// ----------------------------------------------------------------------------
// c2d_checker: port-level checks of the convolution block
// Watches the handshake and the stall path on the top-level ports.
// ----------------------------------------------------------------------------
module c2d_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] red_out_o,
  input logic [7:0] green_out_o,
  input logic [7:0] blue_out_o,
  input logic       frame_last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(red_out_o) && $stable(green_out_o) &&
      $stable(blue_out_o) && $stable(frame_last_o))
    else $error("output payload changed while stalled");

  a_stall_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with an empty output register");

  a_stall_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_stall_i)
    else $error("input stalled without a downstream stall");

endmodule

bind conv2d_5x5_rgb_clamp c2d_checker u_c2d_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .red_out_o    (red_out_o),
  .green_out_o  (green_out_o),
  .blue_out_o   (blue_out_o),
  .frame_last_o (frame_last_o)
);

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for the streaming 5x5 RGB convolution
// A predictor with its own pixel history and raster counters works out each
// convolved pixel. Frames of several sizes and kernels are streamed through
// the block with random idling on both sides, then drained with flush ticks.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import c2d_pkg::*;

  localparam logic FN_PIXEL = 1'b0;
  localparam logic FN_FLUSH = 1'b1;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       last;
  } opix_t;

  // Scoreboard: a model of the convolution plus the queue of pixels still owed.
  class conv_scoreboard;
    logic [MASK_W-1:0] kernel [5];
    logic [10:0] width_reg, height_reg;
    logic [23:0] history [HIST_DEPTH];
    int wr_ptr, newest_ptr;
    longint newest;
    int in_col, in_row, out_col, out_row;
    opix_t owed [$];
    int mismatches, checked;

    function void clear();
      foreach (kernel[i]) kernel[i] = '0;
      kernel[2] = MASK_ROW2_RST;
      width_reg = 11'd1024;
      height_reg = 11'd1024;
      wr_ptr = 0; newest_ptr = 0; newest = -1;
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      mismatches = 0; checked = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [MASK_W-1:0] val);
      if (idx <= CFG_MASK4) kernel[idx] = val;
      else if (idx == CFG_WIDTH) width_reg = val[10:0];
      else height_reg = val[10:0];
    endfunction

    function int eff_w();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return int'(width_reg);
    endfunction

    function int eff_h();
      if (height_reg == 0) return 1;
      if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
      return int'(height_reg);
    endfunction

    function opix_t convolve(int w, int h);
      longint acc [3];
      longint rr, cc, age, t;
      logic signed [11:0] k;
      logic [23:0] px;
      int idx;
      opix_t o;
      acc[0] = 0; acc[1] = 0; acc[2] = 0;
      for (int dy = 0; dy < 5; dy++)
        for (int dx = 0; dx < 5; dx++) begin
          rr = out_row + dy - RADIUS;
          cc = out_col + dx - RADIUS;
          if (rr < 0 || rr >= h || cc < 0 || cc >= w) continue;
          age = newest - (rr * w + cc);
          if (newest < 0 || age < 0 || age >= HIST_DEPTH) continue;
          idx = (newest_ptr + HIST_DEPTH - int'(age)) % HIST_DEPTH;
          k = kernel[dy][12*dx +: 12];
          px = history[idx];
          acc[0] += longint'(px[23:16]) * longint'(k);
          acc[1] += longint'(px[15:8]) * longint'(k);
          acc[2] += longint'(px[7:0]) * longint'(k);
        end
      for (int c = 0; c < 3; c++) begin
        t = acc[c] + 512;
        acc[c] = (t <= 0) ? 0 : ((t >>> 10) > 255 ? 255 : (t >>> 10));
      end
      o.r = acc[0][7:0]; o.g = acc[1][7:0]; o.b = acc[2][7:0];
      o.last = (out_row == h - 1 && out_col == w - 1);
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
      return o;
    endfunction

    // Notes one accepted input transfer and queues the pixel it produces.
    function void note_input(logic fn, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int w, h;
      longint lin;
      w = eff_w();
      h = eff_h();
      if (fn == FN_PIXEL) begin
        if (in_row >= h) begin
          in_row = 0; in_col = 0; out_row = 0; out_col = 0; newest = -1;
        end
        lin = longint'(in_row) * w + in_col;
        history[wr_ptr] = {r, g, b};
        newest_ptr = wr_ptr;
        wr_ptr = (wr_ptr + 1) % HIST_DEPTH;
        newest = lin;
        in_col++;
        if (in_col >= w) begin
          in_col = 0;
          in_row++;
        end
        if (lin >= RADIUS * w + RADIUS && out_row < h) owed.push_back(convolve(w, h));
      end else if (in_row >= h && out_row < h) begin
        owed.push_back(convolve(w, h));
      end
    endfunction

    function void check_output(opix_t got);
      opix_t exp_pix;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected output pixel %p", got);
        return;
      end
      exp_pix = owed.pop_front();
      checked++;
      if (got !== exp_pix) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: pixel %0d expected r=%0d g=%0d b=%0d last=%0b, %s",
                   checked, exp_pix.r, exp_pix.g, exp_pix.b, exp_pix.last,
                   $sformatf("got r=%0d g=%0d b=%0d last=%0b",
                             got.r, got.g, got.b, got.last));
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [MASK_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic func_i = 1'b0;
  logic [7:0] red_in_i = '0, green_in_i = '0, blue_in_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [7:0] red_out_o, green_out_o, blue_out_o;
  logic frame_last_o;

  conv_scoreboard pixel_sb = new();

  // Idling controls: burst gaps on both sides, off in the last part of the run.
  bit gaps_on = 1'b1;
  bit long_hold = 1'b0;
  int sent_count = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  conv2d_5x5_rgb_clamp i_dut (.*);

  // Output side: checks every transfer and stalls in random bursts. During the
  // long hold it refuses outputs for a long stretch so the pipeline fills up.
  initial begin
    int burst;
    burst = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i)
        pixel_sb.check_output('{red_out_o, green_out_o, blue_out_o, frame_last_o});
      if (long_hold) begin
        out_stall_i <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_stall_i <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 8) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Write enable is dropped by the next item that is sent.
  task automatic write_reg(cfg_idx_e idx, logic [MASK_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    pixel_sb.set_reg(idx, val);
    @(posedge clk_i);
  endtask

  // Presents one item and waits for its transfer; gaps come before it.
  task automatic send_item(logic fn, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    cfg_we_i <= 1'b0;
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= fn;
    red_in_i <= r;
    green_in_i <= g;
    blue_in_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    pixel_sb.note_input(fn, r, g, b);
    sent_count++;
  endtask

  task automatic go_idle();
    int guard;
    in_valid_i <= 1'b0;
    guard = 0;
    while (pixel_sb.owed.size() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    // Flush ticks that produce nothing may still be in flight.
    repeat (16) @(posedge clk_i);
  endtask

  // Streams one frame: pixels of the chosen style, then flushes to drain it.
  task automatic run_frame(int w, int h, int style);
    logic [7:0] r, g, b;
    for (int n = 0; n < w * h; n++) begin
      case (style)
        0: begin r = 8'hFF; g = 8'hFF; b = 8'hFF; end
        1: begin r = 8'h00; g = 8'h00; b = 8'h00; end
        default: begin
          r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
        end
      endcase
      // A stray flush mid-frame must be ignored by the block.
      if ($urandom_range(0, 30) == 0)
        send_item(FN_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
      send_item(FN_PIXEL, r, g, b);
    end
    repeat (RADIUS * w + RADIUS + $urandom_range(0, 2))
      send_item(FN_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  function automatic logic [MASK_W-1:0] random_kernel_row(int kind);
    logic [MASK_W-1:0] v;
    for (int j = 0; j < 5; j++)
      case (kind)
        0: v[12*j +: 12] = 12'h7FF;
        1: v[12*j +: 12] = 12'h800;
        2: v[12*j +: 12] = 12'($urandom_range(0, 160));
        default: v[12*j +: 12] = 12'($urandom);
      endcase
    return v;
  endfunction

  task automatic set_shape(int w, int h);
    write_reg(CFG_WIDTH, MASK_W'(w));
    write_reg(CFG_HEIGHT, MASK_W'(h));
  endtask

  initial begin
    int w, h;
    bit hold_done;
    hold_done = 1'b0;
    pixel_sb.clear();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: identity kernel on tiny frames, extreme pixels, then a
    // single-pixel frame (width and height of zero act as one).
    set_shape(3, 3);
    run_frame(3, 3, 0);
    go_idle();
    set_shape(0, 0);
    run_frame(1, 1, 1);
    go_idle();
    // Largest positive and negative coefficients saturate both ways.
    for (int i = 0; i < 5; i++) write_reg(cfg_idx_e'(i), random_kernel_row(0));
    set_shape(2, 2);
    run_frame(2, 2, 0);
    go_idle();
    for (int i = 0; i < 5; i++) write_reg(cfg_idx_e'(i), random_kernel_row(1));
    run_frame(2, 2, 2);
    go_idle();

    // A width above the maximum acts as the maximum: one full-width row, then
    // a few flushes drain its first outputs. The next frame drops the rest.
    for (int i = 0; i < 5; i++) write_reg(cfg_idx_e'(i), random_kernel_row(2));
    set_shape(2047, 1);
    for (int n = 0; n < MAX_WIDTH; n++)
      send_item(FN_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
    repeat (4) send_item(FN_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
    go_idle();

    // Random part: frames of assorted small shapes and kernels.
    while (sent_count < 1650) begin
      for (int i = 0; i < 5; i++)
        write_reg(cfg_idx_e'(i), random_kernel_row($urandom_range(2, 3)));
      w = $urandom_range(1, 9);
      h = $urandom_range(1, 8);
      set_shape(w, h);
      if (!hold_done) begin
        hold_done = 1'b1;
        // Hold the output off for a long stretch while input keeps coming.
        fork
          begin
            long_hold = 1'b1;
            repeat (300) @(posedge clk_i);
            long_hold = 1'b0;
          end
        join_none
      end
      if (sent_count > 1450) gaps_on = 1'b0;
      // Sometimes a new frame starts before the old one is drained.
      if ($urandom_range(0, 5) == 0) begin
        for (int n = 0; n < w * h; n++)
          send_item(FN_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
      end
      run_frame(w, h, 2);
      go_idle();
    end
    while (long_hold) @(posedge clk_i);
    go_idle();

    $display("Streamed %0d transfers over frames of assorted sizes and kernels,", sent_count);
    $display("including a clipped full-width row; %0d pixels checked, %0d mismatches.",
             pixel_sb.checked, pixel_sb.mismatches);
    if (pixel_sb.mismatches == 0 && pixel_sb.owed.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
